>>> rtl/lkha_pkg.sv
// Shared types and constants for the lowest-k height average block.
// No dependencies; imported by every module of the block.
package lkha_pkg;

  localparam int unsigned HEIGHT_W     = 32;
  localparam int unsigned KEEP_W       = 6;
  localparam int unsigned WIN_W        = 10;
  localparam int unsigned HELD_OUT_W   = 6;
  localparam int unsigned OUT_W        = 40;  // 39 bits of fields, padded to bytes
  localparam int unsigned MAX_KEEP_DEF = 32;
  localparam int unsigned ADDR_W       = 3;

  localparam logic [KEEP_W-1:0] KEEP_RST = KEEP_W'(20);
  localparam logic [WIN_W-1:0]  WIN_RST  = WIN_W'(100);

  // register byte addresses
  localparam logic [ADDR_W-1:0] ADDR_KEEP = ADDR_W'(0);
  localparam logic [ADDR_W-1:0] ADDR_WIN  = ADDR_W'(4);

  // request kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_FRAME  = 1'b1;

  // control shared by all cells of the sorted chain
  typedef struct packed {
    logic ins;  // insert sample at its sorted place, shift larger ones right
    logic shl;  // shift whole chain toward cell 0 (drain for summing)
  } lkha_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUM  = 4'b0010,
    ST_LOAD = 4'b0100,
    ST_DIV  = 4'b1000
  } lkha_state_e;

endpackage

>>> rtl/lowest_k_height_average_core.sv
// Top level of the lowest-k height average block: sorted cell chain, sequencer,
// divider, APB registers and stream ports. Depends on lkha_pkg, lkha_cell, lkha_div.
//
// The block keeps the keep_count smallest signed Q16.16 heights seen since the
// last average in an ascending chain of MAX_KEEP cells. When a height beat is
// taken, every cell compares the sample against its own value and the larger
// entries move one cell right; once the set is full a sample only enters when it
// is strictly below the largest held height, which then falls off the end. An
// end-of-frame beat counts frames; when the count passes frame_window the held
// heights are averaged (sum / count, truncated toward zero), the set is emptied
// and the frame count cleared. Every input beat yields one output beat.
// Height beats and non-averaging frame beats are accepted back to back while
// the output register can take them. An averaging frame beat holds
// s_axis_tready_o low while the chain drains into an accumulator one cell per
// cycle, the divider is loaded, the restoring divider produces one quotient bit
// per cycle and the sequencer returns to idle (SUM_W = 32 + the count width,
// 38 bits at MAX_KEEP = 32). The single output register takes a new beat only
// when it is empty or its result leaves in the same cycle.
// Registers (APB, 32-bit data): 0x0 keep_count (6 bits, reset 20, 0 acts as 1,
// above MAX_KEEP acts as MAX_KEEP), 0x4 frame_window (10 bits, reset 100).
// Lowering keep_count below the held count does not shrink the set.
module lowest_k_height_average_core
  import lkha_pkg::*;
#(
  parameter int unsigned MAX_KEEP = MAX_KEEP_DEF  // 1..64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // height / frame stream in
  input  logic              s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  logic [31:0]       s_axis_tdata_i,   // [31:0] sample_height
  input  logic [0:0]        s_axis_tuser_i,   // [0] req_type
  // result stream out
  output logic              m_axis_tvalid_o,
  input  logic              m_axis_tready_i,
  output logic [OUT_W-1:0]  m_axis_tdata_o,   // [31:0] ground_height, [32] average_updated,
                                              // [38:33] held_values, [39] zero
  // APB register port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  localparam int unsigned CNT_W = $clog2(MAX_KEEP + 1);
  localparam int unsigned CAP_W = KEEP_W + 1;
  localparam int unsigned SUM_W = HEIGHT_W + CNT_W;
  localparam logic [CAP_W-1:0] MAX_KEEP_C = CAP_W'(MAX_KEEP);

  // ---------------- registers ----------------
  logic [KEEP_W-1:0] keep_q;
  logic [WIN_W-1:0]  win_q;
  logic              wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_q <= KEEP_RST;
      win_q  <= WIN_RST;
    end else if (wr_en) begin
      if (paddr == ADDR_KEEP) keep_q <= pwdata[KEEP_W-1:0];
      if (paddr == ADDR_WIN)  win_q  <= pwdata[WIN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == ADDR_KEEP) prdata = 32'(keep_q);
    else if (paddr == ADDR_WIN) prdata = 32'(win_q);
  end

  // ---------------- control state ----------------
  lkha_state_e          state_q, state_d;
  logic [CNT_W-1:0]     held_q, held_d;
  logic [WIN_W-1:0]     fc_q, fc_d;
  logic signed [HEIGHT_W-1:0] avg_q, avg_d;
  logic signed [SUM_W-1:0]    sum_q, sum_d;
  logic [CNT_W-1:0]     den_q, den_d;
  logic                 neg_q, neg_d;
  logic                 ovalid_q, ovalid_d;
  logic [OUT_W-1:0]     odata_q, odata_d;

  logic                 in_acc;
  logic                 is_sample;
  logic [WIN_W:0]       fc_next;
  logic                 do_avg;
  logic [CAP_W-1:0]     keep_ext, cap;
  logic                 full;
  logic                 hit;
  lkha_ctl_t            ctl;

  // chain wiring
  logic signed [HEIGHT_W-1:0] val   [MAX_KEEP];
  logic [MAX_KEEP-1:0]        take;
  logic [MAX_KEEP-1:0]        valid;
  logic signed [HEIGHT_W-1:0] sample;

  // divider
  logic                 div_start;
  logic [SUM_W-1:0]     div_mag;
  logic [SUM_W-1:0]     div_quo;
  logic                 div_done;
  logic [SUM_W-1:0]     quo_signed;

  assign sample    = s_axis_tdata_i;
  assign is_sample = (s_axis_tuser_i[0] == REQ_SAMPLE);

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!ovalid_q || m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  // effective capacity: 0 acts as 1, clamp at MAX_KEEP
  assign keep_ext = CAP_W'(keep_q);
  always_comb begin
    if (keep_q == '0) cap = CAP_W'(1);
    else if (keep_ext > MAX_KEEP_C) cap = MAX_KEEP_C;
    else cap = keep_ext;
  end
  assign full = (CAP_W'(held_q) >= cap);

  // sorted chain: a valid cell taking the sample means sample < largest held
  assign hit = |(take & valid);

  assign fc_next = {1'b0, fc_q} + (WIN_W + 1)'(1);
  assign do_avg  = (fc_next > {1'b0, win_q});

  always_comb begin
    ctl.ins = in_acc && is_sample && (!full || hit);
    ctl.shl = (state_q == ST_SUM);
  end

  genvar gi;
  generate
    for (gi = 0; gi < MAX_KEEP; gi++) begin : g_cell
      logic signed [HEIGHT_W-1:0] lval, rval;
      logic                       ltake;
      assign valid[gi] = (held_q > CNT_W'(gi));
      if (gi == 0) begin : g_first
        assign lval  = '0;
        assign ltake = 1'b0;
      end else begin : g_mid
        assign lval  = val[gi-1];
        assign ltake = take[gi-1];
      end
      if (gi == MAX_KEEP - 1) begin : g_last
        assign rval = '0;
      end else begin : g_notlast
        assign rval = val[gi+1];
      end
      lkha_cell u_cell (
        .clk_i       (clk_i),
        .ctl_i       (ctl),
        .sample_i    (sample),
        .valid_i     (valid[gi]),
        .left_val_i  (lval),
        .left_take_i (ltake),
        .right_val_i (rval),
        .val_o       (val[gi]),
        .take_o      (take[gi])
      );
    end
  endgenerate

  // magnitude into the divider, sign restored on the quotient
  assign div_start  = (state_q == ST_LOAD);
  assign div_mag    = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : SUM_W'(sum_q);
  assign quo_signed = neg_q ? -div_quo : div_quo;

  lkha_div #(
    .DD_W (SUM_W),
    .DV_W (CNT_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_mag),
    .divisor_i  (den_q),
    .quo_o      (div_quo),
    .done_o     (div_done)
  );

  always_comb begin
    state_d  = state_q;
    held_d   = held_q;
    fc_d     = fc_q;
    avg_d    = avg_q;
    sum_d    = sum_q;
    den_d    = den_q;
    neg_d    = neg_q;
    ovalid_d = ovalid_q && !m_axis_tready_i;
    odata_d  = odata_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          if (is_sample) begin
            if (!full) held_d = held_q + CNT_W'(1);
            ovalid_d = 1'b1;
            odata_d  = {1'b0, HELD_OUT_W'(held_d), 1'b0, avg_q};
          end else if (!do_avg) begin
            fc_d     = fc_next[WIN_W-1:0];
            ovalid_d = 1'b1;
            odata_d  = {1'b0, HELD_OUT_W'(held_q), 1'b0, avg_q};
          end else begin
            fc_d = '0;
            if (held_q == '0) begin
              // nothing held: keep the old average
              ovalid_d = 1'b1;
              odata_d  = {1'b0, HELD_OUT_W'(held_q), 1'b0, avg_q};
            end else begin
              sum_d   = '0;
              den_d   = held_q;
              state_d = ST_SUM;
            end
          end
        end
      end
      ST_SUM: begin
        // drain cell 0 into the accumulator, chain shifts left
        sum_d  = sum_q + SUM_W'(val[0]);
        held_d = held_q - CNT_W'(1);
        if (held_q == CNT_W'(1)) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        neg_d   = sum_q[SUM_W-1];
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          avg_d    = quo_signed[HEIGHT_W-1:0];
          ovalid_d = 1'b1;
          odata_d  = {1'b0, HELD_OUT_W'(held_q), 1'b1, quo_signed[HEIGHT_W-1:0]};
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      held_q   <= '0;
      fc_q     <= '0;
      avg_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      held_q   <= held_d;
      fc_q     <= fc_d;
      avg_q    <= avg_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q   <= sum_d;
    den_q   <= den_d;
    neg_q   <= neg_d;
    odata_q <= odata_d;
  end

  assign m_axis_tvalid_o = ovalid_q;
  assign m_axis_tdata_o  = odata_q;

endmodule

>>> rtl/lkha_cell.sv
// One cell of the ascending sorted height chain.
// Depends on lkha_pkg (control struct, height width).
module lkha_cell
  import lkha_pkg::*;
(
  input  logic                       clk_i,
  input  lkha_ctl_t                  ctl_i,
  input  logic signed [HEIGHT_W-1:0] sample_i,
  input  logic                       valid_i,
  input  logic signed [HEIGHT_W-1:0] left_val_i,
  input  logic                       left_take_i,
  input  logic signed [HEIGHT_W-1:0] right_val_i,
  output logic signed [HEIGHT_W-1:0] val_o,
  output logic                       take_o
);

  logic signed [HEIGHT_W-1:0] val_q, val_d;

  // sample belongs here or before: empty slot, or strictly smaller than held
  assign take_o = !valid_i || (sample_i < val_q);

  always_comb begin
    val_d = val_q;
    if (ctl_i.shl) begin
      val_d = right_val_i;
    end else if (ctl_i.ins && take_o) begin
      val_d = left_take_i ? left_val_i : sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

>>> rtl/lkha_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lkha_pkg only through the common import style.
module lkha_div
  import lkha_pkg::*;
#(
  parameter int unsigned DD_W = 38,
  parameter int unsigned DV_W = 6
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic [DD_W-1:0] dividend_i,
  input  logic [DV_W-1:0] divisor_i,
  output logic [DD_W-1:0] quo_o,
  output logic            done_o
);

  localparam int unsigned CNT_W = $clog2(DD_W + 1);

  logic [DV_W:0]   rem_q, rem_d;
  logic [DD_W-1:0] quo_q, quo_d;
  logic [DV_W-1:0] den_q, den_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [DV_W+1:0] trial;

  assign trial = {1'b0, rem_q[DV_W-1:0], quo_q[DD_W-1]} - {2'b00, den_q};

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    den_d  = den_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = '0;
      quo_d  = dividend_i;
      den_d  = divisor_i;
      cnt_d  = CNT_W'(DD_W);
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (trial[DV_W+1]) begin
        rem_d = {rem_q[DV_W-1:0], quo_q[DD_W-1]};
        quo_d = {quo_q[DD_W-2:0], 1'b0};
      end else begin
        rem_d = trial[DV_W:0];
        quo_d = {quo_q[DD_W-2:0], 1'b1};
      end
      cnt_d = cnt_q - CNT_W'(1);
      if (cnt_q == CNT_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    den_q <= den_d;
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

>>> tb/lowest_k_height_average_core_test.sv
// Self-checking test of lowest_k_height_average_core: stream beats in, result beats out.
// Depends on lkha_pkg and the core RTL; a scoreboard class predicts every result beat.
module lowest_k_height_average_core_test;
  import lkha_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_KEEP  = MAX_KEEP_DEF;
  localparam int unsigned RUN_LIMIT = 1_000_000;  // cycles before we call it hung
  localparam int unsigned TAIL_CYC  = 100;        // quiet cycles after the last result
  localparam int unsigned STALL_CYC = 300;        // long receiver hold-off

  // one result beat: the fields carried in m_axis_tdata_o, in another bit order
  typedef struct packed {
    logic [31:0] ground;
    logic        updated;
    logic [5:0]  held;
  } ground_result_t;

  // Predicts ground height, update flag and held count for each accepted beat,
  // and checks result beats against the oldest prediction.
  class ground_height_board;
    logic signed [31:0] lowest [MAX_KEEP];  // unordered copy of the held set
    int unsigned        held_n;
    int unsigned        frame_n;
    logic signed [31:0] avg;
    logic [5:0]         keep;
    logic [9:0]         window;
    ground_result_t     expected_grounds[$];
    int unsigned        mismatches;

    function new();
      held_n      = 0;
      frame_n     = 0;
      avg         = '0;
      keep        = KEEP_RST;
      window      = WIN_RST;
      mismatches  = 0;
    endfunction

    function void set_keep(logic [31:0] v);
      keep = v[5:0];
    endfunction

    function void set_window(logic [31:0] v);
      window = v[9:0];
    endfunction

    function int unsigned pending();
      return expected_grounds.size();
    endfunction

    // keep_count 0 behaves as 1, anything above MAX_KEEP as MAX_KEEP
    function int unsigned capacity();
      int unsigned c;
      c = keep;
      if (c < 1) c = 1;
      if (c > MAX_KEEP) c = MAX_KEEP;
      return c;
    endfunction

    function void note_height_beat(logic req, logic signed [31:0] h);
      int unsigned    top;
      int unsigned    next_n;
      longint         total;
      logic           upd;
      ground_result_t r;
      upd = 1'b0;
      if (req == REQ_SAMPLE) begin
        if (held_n < capacity()) begin
          lowest[held_n] = h;
          held_n++;
        end else begin
          // full (or overfull after keep was lowered): replace the largest if strictly below
          top = 0;
          for (int i = 1; i < held_n; i++)
            if (lowest[i] > lowest[top]) top = i;
          if (h < lowest[top]) lowest[top] = h;
        end
      end else begin
        next_n = frame_n + 1;  // compared before it is stored
        if (next_n > window) begin
          if (held_n != 0) begin
            total = 0;
            for (int i = 0; i < held_n; i++) total += lowest[i];
            avg    = 32'(total / longint'(held_n));  // truncates toward zero
            held_n = 0;
            upd    = 1'b1;
          end
          frame_n = 0;
        end else begin
          frame_n = next_n;
        end
      end
      r.ground  = avg;
      r.updated = upd;
      r.held    = 6'(held_n);
      expected_grounds = {expected_grounds, r};
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        $display("%0t: %s expected %h actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_ground_beat(logic [OUT_W-1:0] beat);
      ground_result_t want;
      if (expected_grounds.size() == 0) begin
        $display("%0t: result beat %h with no expected result", $time, beat);
        mismatches++;
        return;
      end
      want = expected_grounds.pop_front();
      compare_field("ground_height", want.ground, beat[31:0]);
      compare_field("average_updated", 32'(want.updated), 32'(beat[32]));
      compare_field("held_values", 32'(want.held), 32'(beat[38:33]));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [31:0]       s_tdata = '0;    // [31:0] sample_height
  logic [0:0]        s_tuser = '0;    // [0] req_type
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;         // [31:0] ground, [32] updated, [38:33] held
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [31:0]       pwdata = '0;
  logic [31:0]       prdata;
  logic              pready;

  ground_height_board board = new();

  bit                 idle_on = 1'b1;     // random gaps on both sides
  int unsigned        stall_order = 0;    // bumped to request a long receiver hold-off
  int unsigned        cycles = 0;
  logic signed [31:0] last_height = '0;

  lowest_k_height_average_core #(.MAX_KEEP(MAX_KEEP)) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #2 clk_i = ~clk_i;

  // Monitor: both handshakes sampled at the edge, before any driver update lands.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_tvalid && s_tready) board.note_height_beat(s_tuser[0], s_tdata);
      if (m_tvalid && m_tready) board.check_ground_beat(m_tdata);
    end
  end

  // Receiver: random back-pressure, plus a long hold-off on request that it
  // counts down itself while the sender keeps pushing beats.
  always @(posedge clk_i) begin
    int unsigned stall_left;
    int unsigned stall_seen;
    if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left--;
    end else if (stall_order != stall_seen) begin
      stall_seen = stall_order;
      stall_left = STALL_CYC;
      m_tready   <= 1'b0;
    end else begin
      m_tready <= !(idle_on && $urandom_range(99) < 20);
    end
  end

  // Watchdog
  initial begin
    while (cycles < RUN_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("[lowest_k_height_average_core] ERROR");
    $finish;
  end

  // One input beat; valid stays high across back-to-back beats.
  task automatic send_beat(logic req, logic signed [31:0] h);
    if (idle_on && $urandom_range(99) < 20) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req;
    s_tdata  <= h;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  task automatic send_sample(logic signed [31:0] h);
    send_beat(REQ_SAMPLE, h);
  endtask

  // height field is don't-care on frame ends, so fill it with noise
  task automatic send_frame();
    send_beat(REQ_FRAME, $urandom);
  endtask

  // Stop offering and wait for every predicted result.
  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  // APB write: setup cycle, access cycle, then an idle wait with psel and penable low.
  task automatic reg_write(logic [ADDR_W-1:0] addr, logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Registers only change with the block idle.
  task automatic configure(logic [31:0] keep, logic [31:0] win);
    drain();
    reg_write(ADDR_KEEP, keep);
    board.set_keep(keep);
    reg_write(ADDR_WIN, win);
    board.set_window(win);
  endtask

  // Heights: extremes, values near zero (lots of ties), repeats, full-range noise.
  function automatic logic signed [31:0] pick_height();
    logic signed [31:0] h;
    case ($urandom_range(9))
      0:       h = 32'sh7FFF_FFFF;
      1:       h = 32'sh8000_0000;
      2, 3:    h = int'($urandom_range(2000)) - 1000;
      4:       h = last_height;
      default: h = $urandom;
    endcase
    last_height = h;
    return h;
  endfunction

  task automatic run_random(int unsigned n, int unsigned frame_pct, int unsigned stall_at);
    for (int unsigned i = 0; i < n; i++) begin
      if (i == stall_at) stall_order++;
      if ($urandom_range(99) < frame_pct) send_frame();
      else send_sample(pick_height());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // window 0: every frame end averages; extremes, a tie with the max, a drop
    configure(3, 0);
    send_sample(32'sh7FFF_FFFF);
    send_sample(32'sh8000_0000);
    send_sample(32'sh0000_0000);
    send_sample(32'shFFFF_FFFF);  // evicts the positive extreme
    send_sample(32'sh0000_0000);  // equals the largest held: dropped
    send_sample(32'sh0000_0005);  // above the largest held: dropped
    send_frame();                 // negative average, truncated toward zero
    send_frame();                 // empty set: average kept, no update

    // keep 0 behaves as a single slot
    configure(0, 1);
    send_sample(32'sd10);
    send_sample(-32'sd7);
    send_sample(32'sd3);
    send_frame();
    send_frame();
    send_frame();
    send_frame();

    // fill six of eight slots, then shrink capacity to two while the set is overfull
    configure(8, 2);
    repeat (6) send_sample(pick_height());
    configure(2, 2);
    send_sample(-32'sd100);
    send_sample(32'sd1000);
    send_sample(32'sh8000_0000);
    repeat (3) send_frame();

    // --- random ---
    configure(63, 3);             // above MAX_KEEP acts as MAX_KEEP
    run_random(100, 15, 30);      // long output hold-off mid-phase
    configure(5, 0);
    run_random(60, 30, 0);
    configure(32, 1);
    idle_on = 1'b0;               // full-rate stretch on both sides
    run_random(100, 20, 1000);
    idle_on = 1'b1;
    configure(1, 4);
    run_random(60, 25, 1000);
    configure(17, 10);
    run_random(80, 10, 1000);
    configure(20, 100);           // reset values
    run_random(40, 50, 1000);
    configure(40, 1023);          // widest window, capacity clamped to MAX_KEEP
    run_random(40, 20, 1000);

    drain();
    repeat (TAIL_CYC) @(posedge clk_i);
    if (board.mismatches == 0)
      $display("[lowest_k_height_average_core] OK");
    else
      $display("[lowest_k_height_average_core] ERROR");
    $finish;
  end

endmodule
